// File: sv/ngtc_pkg.sv
// shared types and constants for the n-gram transition counter
`timescale 1ns / 1ps
`default_nettype none
package ngtc_pkg;

  localparam int unsigned LETTER_BITS      = 5;
  localparam int unsigned KEY_LETTERS_DEF  = 2;
  localparam int unsigned TALLY_BITS_DEF   = 16;
  localparam int unsigned LETTER_COUNT     = 26;
  localparam logic [10:0] COUNT_MAX        = 11'd2047;
  localparam logic [7:0]  LETTER_A         = 8'h61;
  localparam logic [7:0]  LETTER_UPPER_A   = 8'h41;

  typedef enum logic [1:0] {
    ACT_TEXT  = 2'd0,
    ACT_END   = 2'd1,
    ACT_QUERY = 2'd2,
    ACT_COUNT = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    POS_START  = 2'd0,
    POS_WITHIN = 2'd1,
    POS_END    = 2'd2,
    POS_NONE   = 2'd3
  } position_e;

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_WR,
    S_QR,
    S_QE,
    S_QF
  } state_e;

  // tally update request from the word tracker
  typedef struct packed {
    logic valid;
    logic start;
    logic at_end;
  } commit_t;

endpackage
`default_nettype wire

// File: sv/ngtc_word.sv
// word tracker: byte classification, letter window and held transition
`timescale 1ns / 1ps
`default_nettype none
module ngtc_word import ngtc_pkg::*; #(
  parameter int unsigned KEY_LETTERS = KEY_LETTERS_DEF,
  localparam int unsigned KEY_BITS   = LETTER_BITS * KEY_LETTERS,
  localparam int unsigned ADDR_BITS  = KEY_BITS + LETTER_BITS
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 text_i,
  input  wire logic                 eot_i,
  input  wire logic [7:0]           byte_i,
  output commit_t                   commit_o,
  output logic      [ADDR_BITS-1:0] commit_idx_o
);

  localparam int unsigned WL_BITS = $clog2(KEY_LETTERS + 1);

  logic [KEY_BITS-1:0]    window_q, window_d;
  logic [WL_BITS-1:0]     wl_q, wl_d;
  logic                   held_valid_q, held_valid_d;
  logic                   held_start_q, held_start_d;
  logic [KEY_BITS-1:0]    held_key_q, held_key_d;
  logic [LETTER_BITS-1:0] held_letter_q, held_letter_d;

  logic                   is_sep, is_lower, is_upper, close, letter, full;
  logic [7:0]             diff;
  logic [LETTER_BITS-1:0] code;

  always_comb begin
    is_sep   = byte_i inside {8'h20, 8'h2c, 8'h2d, 8'h3a};
    is_lower = byte_i inside {[8'h61:8'h7a]};
    is_upper = byte_i inside {[8'h41:8'h5a]};
    diff     = byte_i - (is_lower ? LETTER_A : LETTER_UPPER_A);
    code     = diff[LETTER_BITS-1:0];
    close    = eot_i | (text_i & is_sep);
    letter   = text_i & (is_lower | is_upper);
    full     = (32'(wl_q) >= KEY_LETTERS);

    commit_o.valid  = held_valid_q & (close | (letter & full));
    commit_o.start  = held_start_q;
    commit_o.at_end = close;
    commit_idx_o    = {held_key_q, held_letter_q};

    window_d      = window_q;
    wl_d          = wl_q;
    held_valid_d  = held_valid_q;
    held_start_d  = held_start_q;
    held_key_d    = held_key_q;
    held_letter_d = held_letter_q;
    if (close) begin
      window_d      = '0;
      wl_d          = '0;
      held_valid_d  = 1'b0;
      held_start_d  = 1'b0;
      held_key_d    = '0;
      held_letter_d = '0;
    end else if (letter) begin
      if (full) begin
        held_valid_d  = 1'b1;
        held_start_d  = !held_valid_q;
        held_key_d    = window_q;
        held_letter_d = code;
      end else begin
        wl_d = wl_q + 1'b1;
      end
      window_d = KEY_BITS'({window_q, code});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q      <= '0;
      wl_q          <= '0;
      held_valid_q  <= 1'b0;
      held_start_q  <= 1'b0;
      held_key_q    <= '0;
      held_letter_q <= '0;
    end else begin
      window_q      <= window_d;
      wl_q          <= wl_d;
      held_valid_q  <= held_valid_d;
      held_start_q  <= held_start_d;
      held_key_q    <= held_key_d;
      held_letter_q <= held_letter_d;
    end
  end

endmodule
`default_nettype wire

// File: sv/ngram_transition_counter.sv
// top level: tally memory, key memory, query walk and result register
//
// After reset the block sweeps its tally and key memories clear, one entry a
// cycle, over 2**(5*KEY_LETTERS+5) entries (32768 at the default), and takes
// no beat until done. A text byte or end of text that commits a transition
// reads its tally entry when accepted and writes it back in S_WR before the
// next beat is taken. A key count or malformed query answers with a single
// result beat. A valid query walks the 26 letter entries of its key, reading
// each (S_QR) then evaluating it (S_QE), and pauses while the result side
// stalls. New beats are taken only while the result register is free.
`timescale 1ns / 1ps
`default_nettype none
module ngram_transition_counter import ngtc_pkg::*; #(
  parameter int unsigned KEY_LETTERS = KEY_LETTERS_DEF,
  parameter int unsigned TALLY_BITS  = TALLY_BITS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  action_i,
  input  wire logic [7:0]  text_byte_i,
  input  wire logic [15:0] query_key_i,
  input  wire logic [1:0]  position_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             found_o,
  output logic [7:0]       next_letter_o,
  output logic [15:0]      weight_o,
  output logic [10:0]      key_count_o,
  output logic             last_o
);

  localparam int unsigned KEY_BITS  = LETTER_BITS * KEY_LETTERS;
  localparam int unsigned ADDR_BITS = KEY_BITS + LETTER_BITS;
  localparam int unsigned KEY_SPACE = 1 << KEY_BITS;
  localparam int unsigned ENTRIES   = 1 << ADDR_BITS;
  localparam int unsigned TB        = TALLY_BITS;
  localparam logic [TB-1:0] TMAX    = {TB{1'b1}};
  localparam logic [LETTER_BITS-1:0] LAST_LETTER = LETTER_BITS'(LETTER_COUNT - 1);

  logic [3*TB-1:0] tally_mem [ENTRIES];
  logic            seen_mem  [KEY_SPACE];

  state_e state_q, state_d;

  commit_t                word_commit;
  logic [ADDR_BITS-1:0]   word_idx;
  commit_t                cm_q;
  logic [ADDR_BITS-1:0]   cm_idx_q;
  logic [ADDR_BITS-1:0]   clr_q;
  logic [KEY_BITS-1:0]    qkey_q;
  logic [1:0]             pos_q;
  logic [LETTER_BITS-1:0] l_q, l_d;
  logic                   buf_valid_q, buf_valid_d;
  logic [LETTER_BITS-1:0] buf_letter_q, buf_letter_d;
  logic [15:0]            buf_weight_q, buf_weight_d;
  logic [10:0]            distinct_q, distinct_d;
  logic [3*TB-1:0]        rd_q;
  logic                   seen_q;

  logic                   out_valid_q, found_q, last_q;
  logic [7:0]             letter_q;
  logic [15:0]            weight_q;

  logic                   out_free, acc, text_acc, eot_acc;
  logic                   push, push_found, push_last;
  logic [7:0]             push_letter;
  logic [15:0]            push_weight;
  logic                   t_re, t_we, s_we;
  logic [ADDR_BITS-1:0]   t_raddr, t_waddr;
  logic [3*TB-1:0]        t_wdata;
  logic [KEY_BITS-1:0]    s_waddr;
  logic                   s_wdata;
  logic [3*TB-1:0]        upd;
  logic [TB-1:0]          sel_w, sel_w0;
  logic [31:0]            w32;
  logic [15:0]            w16;
  logic                   nz, qe_stall;

  // query key parse: each context byte must be a lowercase letter
  logic [KEY_LETTERS-1:0] qbyte_ok;
  logic [KEY_BITS-1:0]    qkey;
  logic                   qkey_ok;

  for (genvar i = 0; i < KEY_LETTERS; i++) begin : g_qkey
    localparam int unsigned SHIFT = 8 * (KEY_LETTERS - 1 - i);
    logic [7:0] b;
    logic [7:0] d;
    if (SHIFT < 16) begin : g_in
      assign b = query_key_i[SHIFT +: 8];
    end else begin : g_out
      assign b = 8'd0;
    end
    assign d = b - LETTER_A;
    assign qbyte_ok[i] = (b >= LETTER_A) && (b <= 8'h7a);
    assign qkey[(KEY_LETTERS-1-i)*LETTER_BITS +: LETTER_BITS] = d[LETTER_BITS-1:0];
  end
  assign qkey_ok = &qbyte_ok;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && out_free;
  assign acc        = in_valid_i && in_ready_o;
  assign text_acc   = acc && (action_i == ACT_TEXT);
  assign eot_acc    = acc && (action_i == ACT_END);

  ngtc_word #(
    .KEY_LETTERS(KEY_LETTERS)
  ) u_word (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .text_i      (text_acc),
    .eot_i       (eot_acc),
    .byte_i      (text_byte_i),
    .commit_o    (word_commit),
    .commit_idx_o(word_idx)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLR:  if (clr_q == ADDR_BITS'(ENTRIES - 1)) state_d = S_IDLE;
      S_IDLE: begin
        if (acc) begin
          if ((action_i == ACT_QUERY) && qkey_ok) state_d = S_QR;
          else if (word_commit.valid && (text_acc || eot_acc)) state_d = S_WR;
        end
      end
      S_WR:   state_d = S_IDLE;
      S_QR:   state_d = S_QE;
      S_QE:   if (!qe_stall) state_d = (l_q == LAST_LETTER) ? S_QF : S_QR;
      S_QF:   if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    nz    = |rd_q;
    sel_w = '0;
    case (pos_q)
      POS_START:  sel_w = rd_q[0 +: TB];
      POS_WITHIN: sel_w = rd_q[TB +: TB];
      POS_END:    sel_w = rd_q[2*TB +: TB];
      default:    sel_w = '0;
    endcase
    sel_w0 = (sel_w == '0) ? TB'(1) : sel_w;
    w32    = 32'(sel_w0);
    w16    = (w32 > 32'h0000_ffff) ? 16'hffff : w32[15:0];
    qe_stall = nz && buf_valid_q && !out_free;

    // saturating bumps for the commit write back
    upd = rd_q;
    if (cm_q.start && (rd_q[0 +: TB] != TMAX)) upd[0 +: TB] = rd_q[0 +: TB] + 1'b1;
    if (cm_q.at_end) begin
      if (rd_q[2*TB +: TB] != TMAX) upd[2*TB +: TB] = rd_q[2*TB +: TB] + 1'b1;
    end else begin
      if (rd_q[TB +: TB] != TMAX) upd[TB +: TB] = rd_q[TB +: TB] + 1'b1;
    end

    t_re    = 1'b0;
    t_raddr = word_idx;
    t_we    = 1'b0;
    t_waddr = cm_idx_q;
    t_wdata = upd;
    s_we    = 1'b0;
    s_waddr = cm_idx_q[ADDR_BITS-1:LETTER_BITS];
    s_wdata = 1'b1;

    push        = 1'b0;
    push_found  = 1'b0;
    push_letter = 8'd0;
    push_weight = 16'd0;
    push_last   = 1'b1;

    l_d          = l_q;
    buf_valid_d  = buf_valid_q;
    buf_letter_d = buf_letter_q;
    buf_weight_d = buf_weight_q;
    distinct_d   = distinct_q;

    case (state_q)
      S_CLR: begin
        t_we    = 1'b1;
        t_waddr = clr_q;
        t_wdata = '0;
        s_we    = 1'b1;
        s_waddr = clr_q[KEY_BITS-1:0];
        s_wdata = 1'b0;
      end
      S_IDLE: begin
        if (acc) begin
          if ((text_acc || eot_acc) && word_commit.valid) t_re = 1'b1;
          if ((action_i == ACT_COUNT) || ((action_i == ACT_QUERY) && !qkey_ok)) begin
            push = 1'b1;
          end
          l_d         = '0;
          buf_valid_d = 1'b0;
        end
      end
      S_WR: begin
        t_we = 1'b1;
        if (!seen_q) begin
          s_we = 1'b1;
          if (distinct_q != COUNT_MAX) distinct_d = distinct_q + 1'b1;
        end
      end
      S_QR: begin
        t_re    = 1'b1;
        t_raddr = {qkey_q, l_q};
      end
      S_QE: begin
        if (!qe_stall) begin
          if (nz) begin
            if (buf_valid_q) begin
              push        = 1'b1;
              push_found  = 1'b1;
              push_letter = LETTER_A + 8'(buf_letter_q);
              push_weight = buf_weight_q;
              push_last   = 1'b0;
            end
            buf_valid_d  = 1'b1;
            buf_letter_d = l_q;
            buf_weight_d = w16;
          end
          l_d = l_q + 1'b1;
        end
      end
      S_QF: begin
        if (out_free) begin
          push = 1'b1;
          if (buf_valid_q) begin
            push_found  = 1'b1;
            push_letter = LETTER_A + 8'(buf_letter_q);
            push_weight = buf_weight_q;
          end
          buf_valid_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (t_we) tally_mem[t_waddr] <= t_wdata;
    if (t_re) rd_q <= tally_mem[t_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (s_we) seen_mem[s_waddr] <= s_wdata;
    if (t_re) seen_q <= seen_mem[t_raddr[ADDR_BITS-1:LETTER_BITS]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      l_q         <= '0;
      buf_valid_q <= 1'b0;
      distinct_q  <= '0;
      out_valid_q <= 1'b0;
      cm_q        <= '0;
    end else begin
      state_q     <= state_d;
      if (state_q == S_CLR) clr_q <= clr_q + 1'b1;
      l_q         <= l_d;
      buf_valid_q <= buf_valid_d;
      distinct_q  <= distinct_d;
      if (push) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      if (acc) cm_q <= word_commit;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_letter_q <= buf_letter_d;
    buf_weight_q <= buf_weight_d;
    if (acc) begin
      cm_idx_q <= word_idx;
      qkey_q   <= qkey;
      pos_q    <= position_i;
    end
    if (push) begin
      found_q  <= push_found;
      letter_q <= push_letter;
      weight_q <= push_weight;
      last_q   <= push_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign found_o       = found_q;
  assign next_letter_o = letter_q;
  assign weight_o      = weight_q;
  assign key_count_o   = distinct_q;
  assign last_o        = last_q;

  // write back only ever follows a beat that started a commit
  a_wr_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WR) |-> $past(in_valid_i && in_ready_o && word_commit.valid))
    else $error("tally write back without a committing beat");

  // the walk reads no letter slot past the alphabet
  a_walk_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_QR || state_q == S_QE) |-> (l_q <= LAST_LETTER))
    else $error("query walk beyond last letter");

  // a pending beat in the result register is never overwritten
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> $stable(weight_q) && $stable(letter_q))
    else $error("result overwritten while stalled");

  // a query ends with its final beat before the block idles again
  a_query_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_QF && out_free) |=> (out_valid_q && last_q && !buf_valid_q))
    else $error("query closed without a final beat");

endmodule
`default_nettype wire

// File: tb/ngram_transition_scoreboard.sv
// scoreboard: predicts the transition tallies and checks every result beat
`timescale 1ns / 1ps
module ngram_transition_scoreboard import ngtc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  action_i,
  input  logic [7:0]  text_byte_i,
  input  logic [15:0] query_key_i,
  input  logic [1:0]  position_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic        found_i,
  input  logic [7:0]  next_letter_i,
  input  logic [15:0] weight_i,
  input  logic [10:0] key_count_i,
  input  logic        last_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          results_seen_o
);

  typedef struct packed {
    logic        found;
    logic [7:0]  letter;
    logic [15:0] weight;
    logic [10:0] count;
    logic        last;
  } listing_t;

  logic [15:0] tally_q [3][32768];
  bit          key_known [1024];
  logic [10:0] key_total;
  logic [9:0]  window;
  int          word_len;
  bit          held_valid, held_start;
  logic [9:0]  held_key;
  logic [4:0]  held_letter;
  listing_t    listings_due [$];

  function automatic void bump(int which, int idx);
    if (tally_q[which][idx] != 16'hFFFF) tally_q[which][idx]++;
  endfunction

  function automatic void commit_held(bit at_end);
    int idx;
    idx = {held_key, held_letter};
    if (!held_valid) return;
    if (held_start) bump(POS_START, idx);
    bump(at_end ? POS_END : POS_WITHIN, idx);
    if (!key_known[held_key]) begin
      key_known[held_key] = 1;
      if (key_total != COUNT_MAX) key_total++;
    end
    held_valid = 0;
    held_start = 0;
  endfunction

  function automatic void close_word();
    commit_held(1);
    window = '0;
    word_len = 0;
  endfunction

  function automatic void take_letter(logic [4:0] code);
    bit first;
    if (word_len >= 2) begin
      first = !held_valid;
      commit_held(0);
      held_valid = 1;
      held_start = first;
      held_key = window;
      held_letter = code;
    end
    window = {window[4:0], code};
    if (word_len < 2) word_len++;
  endfunction

  function automatic void push_miss();
    listings_due.push_back('{1'b0, 8'd0, 16'd0, key_total, 1'b1});
  endfunction

  function automatic void list_key(logic [15:0] qkey, logic [1:0] pos);
    logic [9:0]  key;
    logic [7:0]  b;
    logic [15:0] w;
    int          idx, top_letter, n;
    top_letter = -1;
    n = 0;
    for (int i = 0; i < 2; i++) begin
      b = (i == 0) ? qkey[15:8] : qkey[7:0];
      if (b < LETTER_A || b > LETTER_A + 8'd25) begin
        push_miss();
        return;
      end
      key = {key[4:0], 5'(b - LETTER_A)};
    end
    if (!key_known[key]) begin
      push_miss();
      return;
    end
    for (int l = 0; l < 26; l++) begin
      idx = {key, 5'(l)};
      if ((tally_q[0][idx] | tally_q[1][idx] | tally_q[2][idx]) != 0) top_letter = l;
    end
    for (int l = 0; l < 26; l++) begin
      idx = {key, 5'(l)};
      if ((tally_q[0][idx] | tally_q[1][idx] | tally_q[2][idx]) == 0) continue;
      w = (pos != POS_NONE) ? tally_q[pos][idx] : 16'd0;
      if (w == 0) w = 16'd1;
      listings_due.push_back('{1'b1, LETTER_A + 8'(l), w, key_total, l == top_letter});
      n++;
    end
    if (n == 0) push_miss();
  endfunction

  initial begin
    for (int p = 0; p < 3; p++)
      for (int i = 0; i < 32768; i++) tally_q[p][i] = '0;
    for (int i = 0; i < 1024; i++) key_known[i] = 0;
    key_total = '0;
    window = '0;
    word_len = 0;
    held_valid = 0;
    held_start = 0;
    held_key = '0;
    held_letter = '0;
    fail_count_o = 0;
    results_seen_o = 0;
  end

  assign pending_o = listings_due.size();

  always @(posedge clk_i) begin
    listing_t want;
    if (rst_ni && in_valid_i && in_ready_i) begin
      case (action_i)
        ACT_TEXT: begin
          if (text_byte_i inside {" ", ",", "-", ":"}) close_word();
          else if (text_byte_i >= LETTER_A && text_byte_i <= LETTER_A + 8'd25)
            take_letter(5'(text_byte_i - LETTER_A));
          else if (text_byte_i >= LETTER_UPPER_A && text_byte_i <= LETTER_UPPER_A + 8'd25)
            take_letter(5'(text_byte_i - LETTER_UPPER_A));
        end
        ACT_END:   close_word();
        ACT_COUNT: push_miss();
        default:   list_key(query_key_i, position_i);
      endcase
    end
    if (rst_ni && out_valid_i && out_ready_i) begin
      results_seen_o++;
      if (listings_due.size() == 0) begin
        $error("result beat with nothing expected");
        fail_count_o++;
      end else begin
        want = listings_due.pop_front();
        if (found_i !== want.found) begin
          $error("found exp %0h got %0h", want.found, found_i);
          fail_count_o++;
        end
        if (next_letter_i !== want.letter) begin
          $error("next_letter exp %0h got %0h", want.letter, next_letter_i);
          fail_count_o++;
        end
        if (weight_i !== want.weight) begin
          $error("weight exp %0h got %0h", want.weight, weight_i);
          fail_count_o++;
        end
        if (key_count_i !== want.count) begin
          $error("key_count exp %0h got %0h", want.count, key_count_i);
          fail_count_o++;
        end
        if (last_i !== want.last) begin
          $error("last exp %0h got %0h", want.last, last_i);
          fail_count_o++;
        end
      end
    end
  end

endmodule

// File: tb/ngram_transition_counter_test.sv
// testbench top: text and query stimulus, flow control and verdict
`timescale 1ns / 1ps
module ngram_transition_counter_test;
  import ngtc_pkg::*;

  localparam int STALL_LIMIT = 200000;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        in_valid_i = 0;
  logic        in_ready_o;
  logic [1:0]  action_i = ACT_TEXT;
  logic [7:0]  text_byte_i = 0;
  logic [15:0] query_key_i = 0;
  logic [1:0]  position_i = POS_START;
  logic        out_valid_o;
  logic        out_ready_i = 0;
  logic        found_o;
  logic [7:0]  next_letter_o;
  logic [15:0] weight_o;
  logic [10:0] key_count_o;
  logic        last_o;
  int          fail_count, pending, results_seen;
  int          send_idle_pct = 0, recv_stall_pct = 0;
  int          quiet_cycles = 0, beats_sent = 0;

  always #5 clk_i = ~clk_i;

  ngram_transition_counter uut (.*);

  ngram_transition_scoreboard sb (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .action_i, .text_byte_i,
    .query_key_i, .position_i, .out_valid_i(out_valid_o), .out_ready_i,
    .found_i(found_o), .next_letter_i(next_letter_o), .weight_i(weight_o),
    .key_count_i(key_count_o), .last_i(last_o), .fail_count_o(fail_count),
    .pending_o(pending), .results_seen_o(results_seen)
  );

  always @(posedge clk_i) out_ready_i <= ($urandom_range(99) >= recv_stall_pct);

  // watchdog: covers the clearing sweep after reset and stalled query walks
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_beat(logic [1:0] act, logic [7:0] b, logic [15:0] key, logic [1:0] pos);
    action_i <= act;
    text_byte_i <= b;
    query_key_i <= key;
    position_i <= pos;
    in_valid_i <= 1;
    do @(posedge clk_i); while (!in_ready_o);
    beats_sent++;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_beat(ACT_TEXT, s[i], 16'd0, POS_START);
  endtask

  task automatic ask_all_positions(logic [15:0] key);
    for (int p = 0; p < 4; p++) send_beat(ACT_QUERY, 8'd0, key, 2'(p));
  endtask

  function automatic logic [7:0] pick_letter();
    logic [7:0] c;
    c = LETTER_A + 8'($urandom_range(5));
    if ($urandom_range(3) == 0) c = c - 8'h20;
    return c;
  endfunction

  task automatic random_phase(int n);
    int          k, len;
    logic [7:0]  seps [4] = '{" ", ",", "-", ":"};
    k = 0;
    while (k < n) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4: begin
          len = $urandom_range(1, 6);
          for (int i = 0; i < len; i++) begin
            send_beat(ACT_TEXT, pick_letter(), 16'($urandom), 2'($urandom));
            if ($urandom_range(15) == 0) begin
              send_beat(ACT_TEXT, 8'($urandom), 16'($urandom), 2'($urandom));
              k++;
            end
          end
          if ($urandom_range(7) == 0) send_beat(ACT_END, 8'($urandom), 16'd0, 2'd0);
          else send_beat(ACT_TEXT, seps[$urandom_range(3)], 16'd0, 2'd0);
          k += len + 1;
        end
        5, 6, 7: begin
          send_beat(ACT_QUERY, 8'($urandom),
                    {LETTER_A + 8'($urandom_range(5)), LETTER_A + 8'($urandom_range(5))},
                    2'($urandom));
          k++;
        end
        8: begin
          send_beat(ACT_QUERY, 8'($urandom), 16'($urandom), 2'($urandom));
          k++;
        end
        default: begin
          send_beat(ACT_COUNT, 8'($urandom), 16'($urandom), 2'($urandom));
          k++;
        end
      endcase
    end
  endtask

  initial begin
    int waited;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1;

    // empty store, then words split every way
    send_beat(ACT_COUNT, 8'd0, 16'd0, POS_START);
    send_beat(ACT_QUERY, 8'd0, "ab", POS_START);
    send_text("abc ABcd,ab-xabz:");
    send_text("ab");
    send_beat(ACT_QUERY, 8'd0, "ab", POS_END);   // open word not yet visible
    send_beat(ACT_END, 8'd0, 16'd0, POS_START);
    send_text("a1b!ce ");
    ask_all_positions("ab");
    send_beat(ACT_QUERY, 8'd0, "AB", POS_START);
    send_beat(ACT_QUERY, 8'd0, 16'hFFFF, POS_START);
    send_beat(ACT_QUERY, 8'd0, 16'h0000, POS_NONE);
    send_beat(ACT_QUERY, 8'd0, "zz", POS_WITHIN);

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1) ? 57 : (ph == 3) ? 30 : 0;
      recv_stall_pct = (ph == 2) ? 57 : (ph == 3) ? 30 : 0;
      random_phase(28);
    end
    in_valid_i <= 0;

    waited = 0;
    while (pending != 0 && waited < STALL_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (80) @(posedge clk_i);

    $display("covered %0d input beats over four flow-control phases, %0d result beats",
             beats_sent, results_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
